FILE: design/edmc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// edmc_pkg
// Shared types and constants for the encoder distance move controller.
// ---------------------------------------------------------------------------
package edmc_pkg;

	// configuration register indexes
	localparam logic [0:0] CFG_PWM_TOP = 1'd0;
	localparam logic [0:0] CFG_TIMEOUT = 1'd1;

	// request kinds
	localparam logic REQ_CMD  = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	localparam logic [15:0] PWM_TOP_RST = 16'd16000;
	localparam logic [15:0] TIMEOUT_RST = 16'd30000;

	localparam logic [7:0] SPEED_MIN = 8'd5;
	localparam logic [7:0] SPEED_MAX = 8'd100;

	localparam logic [15:0] FWD_LIMIT  = 16'd32768;
	localparam logic [15:0] SPIN_LOW   = 16'd20;
	localparam logic [15:0] SPIN_HIGH  = 16'd65516;
	localparam logic [15:0] TICKS_MAX  = 16'hFFFF;

	// x / 100 == (x * DIV100_MAGIC) >> DIV100_SHIFT for any x below 2**32
	localparam int          PROD_W       = 23;
	localparam int          MAGIC_W      = 31;
	localparam int          SCALED_W     = PROD_W + MAGIC_W;
	localparam int          DIV100_SHIFT = 37;
	localparam logic [30:0] DIV100_MAGIC = 31'd1374389535;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_CLEAR = 2'd1,
		PH_DRIVE = 2'd2,
		PH_STOP  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		DIR_FWD    = 2'd0,
		DIR_BACK   = 2'd1,
		DIR_SPIN_L = 2'd2,
		DIR_SPIN_R = 2'd3
	} dir_t;

	typedef struct packed {
		logic        req_type;
		logic [1:0]  move_dir;
		logic [7:0]  drive_speed;
		logic [15:0] move_distance;
		logic [15:0] encoder_count;
	} item_t;

	// state after one transaction, as needed to build its result
	typedef struct packed {
		phase_t      phase;
		dir_t        dir;
		logic [6:0]  speed;
		logic        done;
		logic [15:0] last_moved;
		logic [15:0] pwm_top;
	} snap_t;

endpackage

FILE: design/edmc_req_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// edmc_req_if
// Request channel: move commands and encoder ticks.
// ---------------------------------------------------------------------------
interface edmc_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [1:0]  move_dir;
	logic [7:0]  drive_speed;
	logic [15:0] move_distance;
	logic [15:0] encoder_count;

	modport source (
		output valid, req_type, move_dir, drive_speed, move_distance, encoder_count,
		input  ready
	);
	modport sink (
		input  valid, req_type, move_dir, drive_speed, move_distance, encoder_count,
		output ready
	);
endinterface

FILE: design/edmc_res_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// edmc_res_if
// Result channel: PWM compares, flags and move status.
// ---------------------------------------------------------------------------
interface edmc_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] left_fwd_compare;
	logic [15:0] left_rev_compare;
	logic [15:0] right_fwd_compare;
	logic [15:0] right_rev_compare;
	logic [3:0]  invert_flags;
	logic        clear_request;
	logic        move_done;
	logic [15:0] moved_count;
	logic        busy_res;

	modport source (
		output valid, left_fwd_compare, left_rev_compare, right_fwd_compare,
			right_rev_compare, invert_flags, clear_request, move_done, moved_count,
			busy_res,
		input  ready
	);
	modport sink (
		input  valid, left_fwd_compare, left_rev_compare, right_fwd_compare,
			right_rev_compare, invert_flags, clear_request, move_done, moved_count,
			busy_res,
		output ready
	);
endinterface

FILE: design/encoder_distance_move_controller.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// encoder_distance_move_controller
// Two-wheel move sequencer with encoder distance stop and PWM compare output.
// ---------------------------------------------------------------------------
//  channel | dir | contents
//  --------+-----+----------------------------------------------------------
//  req     | in  | command or tick: type, direction, speed, distance, count
//  res     | out | four compares, invert flags, clear, done, moved, busy
//  cfg     | in  | write enable, index (0 pwm_top, 1 timeout_ticks), data
//
// One transaction accepted per cycle while req.ready is high.
// Move state updates at acceptance; the product stage and the result register
// behind it each hold one transaction, and req.ready drops only when both are
// full and res is stalled. Reset: idle phase, pwm_top 16000, timeout 30000.
// ---------------------------------------------------------------------------
module encoder_distance_move_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	edmc_req_if.sink    req,
	edmc_res_if.source  res
);

	edmc_pkg::item_t item;
	edmc_pkg::snap_t snap;
	logic            can_take;
	logic            take;

	assign req.ready = can_take;
	assign take      = req.valid && can_take;

	always_comb begin
		item.req_type      = req.req_type;
		item.move_dir      = req.move_dir;
		item.drive_speed   = req.drive_speed;
		item.move_distance = req.move_distance;
		item.encoder_count = req.encoder_count;
	end

	edmc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.item      (item),
		.snap      (snap)
	);

	edmc_drive u_drive (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.snap     (snap),
		.can_take (can_take),
		.res      (res)
	);

endmodule

FILE: design/edmc_seq.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// edmc_seq
// Move sequencer: config registers, phase machine, tick counter, stop rules.
// ---------------------------------------------------------------------------
module edmc_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [0:0]     cfg_index,
	input  logic [15:0]    cfg_data,
	input  logic           take,
	input  edmc_pkg::item_t item,
	output edmc_pkg::snap_t snap
);

	logic [15:0]       pwm_top_q;
	logic [15:0]       timeout_q;
	edmc_pkg::phase_t  phase_q, phase_n;
	edmc_pkg::dir_t    dir_q, dir_n;
	logic [6:0]        speed_q, speed_n;
	logic [15:0]       target_q, target_n;
	logic [15:0]       elapsed_q, elapsed_n;
	logic [15:0]       moved_q, moved_n;
	logic              done;

	logic [7:0]  sp_clamped;
	logic [15:0] cnt;
	logic [15:0] cnt_neg;
	logic [15:0] ticks_inc;
	logic        win;
	logic        tmo;
	logic [15:0] moved;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_top_q <= edmc_pkg::PWM_TOP_RST;
			timeout_q <= edmc_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				edmc_pkg::CFG_PWM_TOP: pwm_top_q <= cfg_data;
				edmc_pkg::CFG_TIMEOUT: timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= edmc_pkg::PH_IDLE;
			dir_q     <= edmc_pkg::DIR_FWD;
			speed_q   <= '0;
			target_q  <= '0;
			elapsed_q <= '0;
			moved_q   <= '0;
		end else if (take) begin
			phase_q   <= phase_n;
			dir_q     <= dir_n;
			speed_q   <= speed_n;
			target_q  <= target_n;
			elapsed_q <= elapsed_n;
			moved_q   <= moved_n;
		end
	end

	assign cnt     = item.encoder_count;
	assign cnt_neg = 16'(17'h10000 - {1'b0, cnt});

	// saturating tick count as it stands after this tick
	assign ticks_inc = (elapsed_q != edmc_pkg::TICKS_MAX) ? elapsed_q + 16'd1 : elapsed_q;

	always_comb begin
		sp_clamped = item.drive_speed;
		if (sp_clamped > edmc_pkg::SPEED_MAX)
			sp_clamped = edmc_pkg::SPEED_MAX;
		else if (sp_clamped != 8'd0 && sp_clamped < edmc_pkg::SPEED_MIN)
			sp_clamped = edmc_pkg::SPEED_MIN;
	end

	// stop rules against the already incremented tick count
	always_comb begin
		case (dir_q)
			edmc_pkg::DIR_FWD: begin
				win   = (cnt != 16'd0) && (cnt < edmc_pkg::FWD_LIMIT);
				moved = cnt;
				tmo   = ticks_inc >= timeout_q;
			end
			edmc_pkg::DIR_BACK: begin
				win   = cnt > edmc_pkg::FWD_LIMIT;
				moved = cnt_neg;
				tmo   = ticks_inc > timeout_q;
			end
			edmc_pkg::DIR_SPIN_L: begin
				win   = (cnt > edmc_pkg::SPIN_LOW) && (cnt < edmc_pkg::SPIN_HIGH);
				moved = cnt_neg;
				tmo   = ticks_inc > timeout_q;
			end
			default: begin
				win   = (cnt > edmc_pkg::SPIN_LOW) && (cnt < edmc_pkg::SPIN_HIGH);
				moved = cnt;
				tmo   = ticks_inc >= timeout_q;
			end
		endcase
	end

	always_comb begin
		phase_n   = phase_q;
		dir_n     = dir_q;
		speed_n   = speed_q;
		target_n  = target_q;
		elapsed_n = elapsed_q;
		moved_n   = moved_q;
		done      = 1'b0;
		if (item.req_type == edmc_pkg::REQ_CMD) begin
			phase_n   = edmc_pkg::PH_CLEAR;
			dir_n     = edmc_pkg::dir_t'(item.move_dir);
			speed_n   = sp_clamped[6:0];
			target_n  = item.move_distance;
			elapsed_n = '0;
		end else if (phase_q == edmc_pkg::PH_CLEAR || phase_q == edmc_pkg::PH_DRIVE) begin
			elapsed_n = ticks_inc;
			case (phase_q)
				edmc_pkg::PH_CLEAR: begin
					if (cnt == 16'd0)
						phase_n = edmc_pkg::PH_DRIVE;
				end
				default: begin
					if ((win && moved >= target_q) || tmo) begin
						phase_n = edmc_pkg::PH_STOP;
						moved_n = moved;
						done    = 1'b1;
					end
				end
			endcase
		end
	end

	always_comb begin
		snap.phase      = phase_n;
		snap.dir        = dir_n;
		snap.speed      = speed_n;
		snap.done       = done;
		snap.last_moved = moved_n;
		snap.pwm_top    = pwm_top_q;
	end

endmodule

FILE: design/edmc_drive.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// edmc_drive
// Compare generation: speed product stage, divide by 100 and channel
// selection into the result register.
// ---------------------------------------------------------------------------
module edmc_drive (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  edmc_pkg::snap_t snap,
	output logic            can_take,
	edmc_res_if.source      res
);

	logic                        valid_s1;
	edmc_pkg::snap_t             snap_s1;
	logic [edmc_pkg::PROD_W-1:0] prod_s1;

	logic        out_valid_q;
	logic [15:0] cmp_q [4];
	logic [3:0]  inv_q;
	logic        clear_q;
	logic        done_q;
	logic [15:0] moved_q;
	logic        busy_q;

	logic                          out_free;
	logic [edmc_pkg::SCALED_W-1:0] scaled;
	logic [15:0]                   duty;
	logic [15:0]                   raw [4];
	logic [15:0]                   cmp [4];
	logic [3:0]                    inv;

	assign out_free = !out_valid_q || res.ready;
	assign can_take = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (can_take)
				valid_s1 <= take;
			if (out_free)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && take) begin
			snap_s1 <= snap;
			prod_s1 <= edmc_pkg::PROD_W'(snap.pwm_top * snap.speed);
		end
	end

	assign scaled = edmc_pkg::SCALED_W'(prod_s1) * edmc_pkg::SCALED_W'(edmc_pkg::DIV100_MAGIC);
	assign duty   = scaled[edmc_pkg::DIV100_SHIFT +: 16];

	// channel order: left fwd, left rev, right fwd, right rev
	always_comb begin
		for (int i = 0; i < 4; i++)
			raw[i] = 16'd0;
		case (snap_s1.phase)
			edmc_pkg::PH_STOP: begin
				for (int i = 0; i < 4; i++)
					raw[i] = snap_s1.pwm_top;
			end
			edmc_pkg::PH_DRIVE: begin
				if (snap_s1.speed == 7'd0) begin
					for (int i = 0; i < 4; i++)
						raw[i] = snap_s1.pwm_top;
				end else begin
					case (snap_s1.dir)
						edmc_pkg::DIR_FWD: begin
							raw[0] = duty;
							raw[2] = duty;
						end
						edmc_pkg::DIR_BACK: begin
							raw[1] = duty;
							raw[3] = duty;
						end
						edmc_pkg::DIR_SPIN_L: begin
							raw[1] = duty;
							raw[2] = duty;
						end
						default: begin
							raw[0] = duty;
							raw[3] = duty;
						end
					endcase
				end
			end
			default: ;
		endcase
		// zero duty is sent as a full count with the output inverted
		for (int i = 0; i < 4; i++) begin
			cmp[i] = raw[i];
			inv[i] = 1'b0;
			if (raw[i] == 16'd0) begin
				cmp[i] = snap_s1.pwm_top;
				inv[i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			for (int i = 0; i < 4; i++)
				cmp_q[i] <= cmp[i];
			inv_q   <= inv;
			clear_q <= snap_s1.phase == edmc_pkg::PH_CLEAR;
			busy_q  <= snap_s1.phase == edmc_pkg::PH_CLEAR
				|| snap_s1.phase == edmc_pkg::PH_DRIVE;
			done_q  <= snap_s1.done;
			moved_q <= snap_s1.last_moved;
		end
	end

	assign res.valid             = out_valid_q;
	assign res.left_fwd_compare  = cmp_q[0];
	assign res.left_rev_compare  = cmp_q[1];
	assign res.right_fwd_compare = cmp_q[2];
	assign res.right_rev_compare = cmp_q[3];
	assign res.invert_flags      = inv_q;
	assign res.clear_request     = clear_q;
	assign res.move_done         = done_q;
	assign res.moved_count       = moved_q;
	assign res.busy_res          = busy_q;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the encoder distance move controller. Commands and
// encoder ticks stream in through the request channel, with random gaps on
// the request side and random stalls on the result side. Each accepted
// transaction runs through a local model of the move sequencer. Every result
// is compared field by field with the oldest prediction. Between phases the
// PWM period and the tick timeout are rewritten, extremes included.
// ---------------------------------------------------------------------------
module tb_top;
	import edmc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic [15:0] left_fwd_compare;
		logic [15:0] left_rev_compare;
		logic [15:0] right_fwd_compare;
		logic [15:0] right_rev_compare;
		logic [3:0]  invert_flags;
		logic        clear_request;
		logic        move_done;
		logic [15:0] moved_count;
		logic        busy_res;
	} motor_out_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [15:0] cfg_data;

	edmc_req_if req_ch ();
	edmc_res_if res_ch ();

	encoder_distance_move_controller u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.res       (res_ch)
	);

	always #6 clk = ~clk;

	// local copy of the move sequencer
	logic [15:0] cfg_pwm_top = PWM_TOP_RST;
	logic [15:0] cfg_timeout = TIMEOUT_RST;
	phase_t      mv_phase    = PH_IDLE;
	dir_t        mv_dir      = DIR_FWD;
	logic [6:0]  mv_speed    = '0;
	logic [15:0] mv_target   = '0;
	logic [15:0] mv_ticks    = '0;
	logic [15:0] mv_last     = '0;

	item_t       move_req_q[$];
	motor_out_t  motor_out_q[$];

	item_t       drv_item;
	motor_out_t  seen;
	motor_out_t  want;
	int unsigned src_gap     = 0;
	int unsigned snk_stall   = 0;
	bit          src_burst   = 1'b0;
	bit          snk_burst   = 1'b0;
	int unsigned mismatch_cnt = 0;
	int unsigned cycle_cnt   = 0;

	function automatic motor_out_t advance_move(item_t it);
		motor_out_t  o;
		logic [7:0]  sp;
		logic [15:0] c;
		logic [15:0] moved;
		logic        win;
		logic        tmo;
		logic [31:0] duty;
		logic [15:0] cmp[4];
		int          sgn[2];
		o = '0;
		if (it.req_type == REQ_CMD) begin
			sp = it.drive_speed;
			if (sp > SPEED_MAX)
				sp = SPEED_MAX;
			else if (sp != 0 && sp < SPEED_MIN)
				sp = SPEED_MIN;
			mv_dir    = dir_t'(it.move_dir);
			mv_speed  = sp[6:0];
			mv_target = it.move_distance;
			mv_ticks  = '0;
			mv_phase  = PH_CLEAR;
		end else if (mv_phase == PH_CLEAR || mv_phase == PH_DRIVE) begin
			c = it.encoder_count;
			if (mv_ticks != TICKS_MAX)
				mv_ticks++;
			if (mv_phase == PH_CLEAR) begin
				if (c == 0)
					mv_phase = PH_DRIVE;
			end else begin
				case (mv_dir)
					DIR_FWD: begin
						win   = c != 0 && c < FWD_LIMIT;
						moved = c;
						tmo   = mv_ticks >= cfg_timeout;
					end
					DIR_BACK: begin
						win   = c > FWD_LIMIT;
						moved = 16'h0 - c;
						tmo   = mv_ticks > cfg_timeout;
					end
					DIR_SPIN_L: begin
						win   = c > SPIN_LOW && c < SPIN_HIGH;
						moved = 16'h0 - c;
						tmo   = mv_ticks > cfg_timeout;
					end
					default: begin
						win   = c > SPIN_LOW && c < SPIN_HIGH;
						moved = c;
						tmo   = mv_ticks >= cfg_timeout;
					end
				endcase
				if ((win && moved >= mv_target) || tmo) begin
					mv_phase    = PH_STOP;
					mv_last     = moved;
					o.move_done = 1'b1;
				end
			end
		end

		// compares: idle and clearing leave everything at zero (inverted)
		for (int i = 0; i < 4; i++)
			cmp[i] = '0;
		duty = (32'(cfg_pwm_top) * 32'(mv_speed)) / 32'd100;
		if (mv_phase == PH_STOP) begin
			for (int i = 0; i < 4; i++)
				cmp[i] = cfg_pwm_top;
		end else if (mv_phase == PH_DRIVE) begin
			case (mv_dir)
				DIR_FWD:    begin sgn[0] = 1;  sgn[1] = 1;  end
				DIR_BACK:   begin sgn[0] = -1; sgn[1] = -1; end
				DIR_SPIN_L: begin sgn[0] = -1; sgn[1] = 1;  end
				default:    begin sgn[0] = 1;  sgn[1] = -1; end
			endcase
			if (mv_speed == 0) begin
				sgn[0] = 0;
				sgn[1] = 0;
			end
			for (int w = 0; w < 2; w++) begin
				if (sgn[w] == 0) begin
					cmp[2*w]   = cfg_pwm_top;
					cmp[2*w+1] = cfg_pwm_top;
				end else if (sgn[w] > 0) begin
					cmp[2*w] = duty[15:0];
				end else begin
					cmp[2*w+1] = duty[15:0];
				end
			end
		end
		for (int i = 0; i < 4; i++) begin
			if (cmp[i] == 0) begin
				cmp[i]            = cfg_pwm_top;
				o.invert_flags[i] = 1'b1;
			end
		end
		o.left_fwd_compare  = cmp[0];
		o.left_rev_compare  = cmp[1];
		o.right_fwd_compare = cmp[2];
		o.right_rev_compare = cmp[3];
		o.clear_request     = mv_phase == PH_CLEAR;
		o.moved_count       = mv_last;
		o.busy_res          = mv_phase == PH_CLEAR || mv_phase == PH_DRIVE;
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] exp_val);
		if (mismatch_cnt < 40)
			$display("%0t mismatch %s: got %h expected %h", $time, what, got, exp_val);
		mismatch_cnt++;
	endtask

	task automatic check_field(string what, logic [15:0] got, logic [15:0] exp_val);
		if (got !== exp_val)
			report_mismatch(what, got, exp_val);
	endtask

	// mostly short idles, a few long ones
	function automatic int unsigned pick_idle();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic item_t tick_item(logic [15:0] cnt);
		item_t it;
		it.req_type      = REQ_TICK;
		it.move_dir      = 2'($urandom_range(0, 3));
		it.drive_speed   = 8'($urandom);
		it.move_distance = 16'($urandom);
		it.encoder_count = cnt;
		return it;
	endfunction

	function automatic item_t cmd_item(dir_t d, logic [7:0] sp, logic [15:0] goal);
		item_t it;
		it.req_type      = REQ_CMD;
		it.move_dir      = d;
		it.drive_speed   = sp;
		it.move_distance = goal;
		it.encoder_count = 16'($urandom);
		return it;
	endfunction

	// request driver
	always @(posedge clk) begin
		if (req_ch.valid && req_ch.ready) begin
			motor_out_q.push_back(advance_move(drv_item));
			if ($urandom_range(0, 149) == 0)
				src_burst = !src_burst;
		end
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (src_gap > 0) begin
				src_gap--;
				req_ch.valid <= 1'b0;
			end else if (move_req_q.size() > 0) begin
				drv_item = move_req_q.pop_front();
				req_ch.valid         <= 1'b1;
				req_ch.req_type      <= drv_item.req_type;
				req_ch.move_dir      <= drv_item.move_dir;
				req_ch.drive_speed   <= drv_item.drive_speed;
				req_ch.move_distance <= drv_item.move_distance;
				req_ch.encoder_count <= drv_item.encoder_count;
				src_gap = src_burst ? 0 : pick_idle();
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// result monitor and back-pressure
	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready) begin
			seen.left_fwd_compare  = res_ch.left_fwd_compare;
			seen.left_rev_compare  = res_ch.left_rev_compare;
			seen.right_fwd_compare = res_ch.right_fwd_compare;
			seen.right_rev_compare = res_ch.right_rev_compare;
			seen.invert_flags      = res_ch.invert_flags;
			seen.clear_request     = res_ch.clear_request;
			seen.move_done         = res_ch.move_done;
			seen.moved_count       = res_ch.moved_count;
			seen.busy_res          = res_ch.busy_res;
			if (motor_out_q.size() == 0) begin
				report_mismatch("result with nothing pending", '0, '0);
			end else begin
				want = motor_out_q.pop_front();
				check_field("left_fwd_compare", seen.left_fwd_compare, want.left_fwd_compare);
				check_field("left_rev_compare", seen.left_rev_compare, want.left_rev_compare);
				check_field("right_fwd_compare", seen.right_fwd_compare,
					want.right_fwd_compare);
				check_field("right_rev_compare", seen.right_rev_compare,
					want.right_rev_compare);
				check_field("invert_flags", 16'(seen.invert_flags), 16'(want.invert_flags));
				check_field("clear_request", 16'(seen.clear_request), 16'(want.clear_request));
				check_field("move_done", 16'(seen.move_done), 16'(want.move_done));
				check_field("moved_count", seen.moved_count, want.moved_count);
				check_field("busy_res", 16'(seen.busy_res), 16'(want.busy_res));
			end
		end
		if ($urandom_range(0, 299) == 0)
			snk_burst = !snk_burst;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (snk_stall > 0) begin
			snk_stall--;
			res_ch.ready <= 1'b0;
		end else if (!snk_burst && $urandom_range(0, 3) == 0) begin
			snk_stall = pick_idle();
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic write_reg(logic [0:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == CFG_PWM_TOP)
			cfg_pwm_top = val;
		else
			cfg_timeout = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every transaction is through, then let the pipeline settle
	task automatic drain();
		@(negedge clk);
		while (move_req_q.size() != 0 || req_ch.valid || motor_out_q.size() != 0)
			@(negedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic queue_directed();
		// tick while idle is ignored
		move_req_q.push_back(tick_item(16'hFFFF));
		// zero speed brakes while driving; nonzero reads keep it clearing
		move_req_q.push_back(cmd_item(DIR_FWD, 8'd0, 16'hFFFF));
		move_req_q.push_back(tick_item(16'd5));
		move_req_q.push_back(tick_item(16'd0));
		move_req_q.push_back(tick_item(16'd100));
		// speed above 100 clamps; forward distance stop, then a tick while stopped
		move_req_q.push_back(cmd_item(DIR_FWD, 8'd255, 16'd100));
		move_req_q.push_back(tick_item(16'd0));
		move_req_q.push_back(tick_item(16'd50));
		move_req_q.push_back(tick_item(16'd100));
		move_req_q.push_back(tick_item(16'd200));
		// low speed clamps to 5; backward window edge at 32768
		move_req_q.push_back(cmd_item(DIR_BACK, 8'd3, 16'd10));
		move_req_q.push_back(tick_item(16'd0));
		move_req_q.push_back(tick_item(16'd32768));
		move_req_q.push_back(tick_item(16'd65530));
		move_req_q.push_back(tick_item(16'd65526));
		// spin left window edges and a zero target
		move_req_q.push_back(cmd_item(DIR_SPIN_L, SPEED_MAX, 16'd0));
		move_req_q.push_back(tick_item(16'd0));
		move_req_q.push_back(tick_item(SPIN_LOW));
		move_req_q.push_back(tick_item(SPIN_HIGH));
		move_req_q.push_back(tick_item(16'd21));
		// a new command replaces a running move
		move_req_q.push_back(cmd_item(DIR_SPIN_R, 8'd4, 16'hFFFF));
		move_req_q.push_back(tick_item(16'd0));
		move_req_q.push_back(cmd_item(DIR_SPIN_R, 8'd1, 16'd30));
		move_req_q.push_back(tick_item(16'd0));
		move_req_q.push_back(tick_item(16'hFFFF));
		move_req_q.push_back(tick_item(16'd30));
	endtask

	// mostly well-formed moves: command, clearing reads, zero read, then
	// counts walking toward the target; some noise and cut-short moves
	task automatic queue_random_moves(int unsigned budget);
		int unsigned added;
		int unsigned cap;
		int unsigned k;
		dir_t        d;
		logic [7:0]  sp;
		logic [15:0] goal;
		logic [15:0] m;
		added = 0;
		while (added < budget) begin
			if ($urandom_range(0, 19) == 0) begin
				move_req_q.push_back(tick_item(16'($urandom)));
				added++;
			end else begin
				d = dir_t'($urandom_range(0, 3));
				case ($urandom_range(0, 9))
					0: sp = 8'd0;
					1: sp = 8'($urandom_range(1, 4));
					2: sp = 8'($urandom_range(101, 255));
					3: sp = SPEED_MAX;
					default: sp = 8'($urandom_range(5, 100));
				endcase
				case ($urandom_range(0, 9))
					0: goal = 16'd0;
					1: goal = 16'($urandom);
					default: goal = 16'($urandom_range(1, 300));
				endcase
				move_req_q.push_back(cmd_item(d, sp, goal));
				added++;
				repeat ($urandom_range(0, 2)) begin
					move_req_q.push_back(tick_item(16'($urandom_range(1, 65535))));
					added++;
				end
				if ($urandom_range(0, 19) != 0) begin
					move_req_q.push_back(tick_item(16'd0));
					added++;
				end
				cap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 40;
				m = '0;
				k = 0;
				while (k < cap && m < goal) begin
					if ($urandom_range(0, 9) == 0) begin
						move_req_q.push_back(tick_item(16'($urandom)));
					end else begin
						m = m + 16'($urandom_range(1, goal / 6 + 2));
						move_req_q.push_back(tick_item(
							(d == DIR_BACK || d == DIR_SPIN_L) ? 16'h0 - m : m));
					end
					added++;
					k++;
				end
				if ($urandom_range(0, 1) == 0) begin
					move_req_q.push_back(tick_item(16'($urandom)));
					added++;
				end
			end
		end
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = CFG_PWM_TOP;
		cfg_data             = '0;
		req_ch.valid         = 1'b0;
		req_ch.req_type      = REQ_CMD;
		req_ch.move_dir      = '0;
		req_ch.drive_speed   = '0;
		req_ch.move_distance = '0;
		req_ch.encoder_count = '0;
		res_ch.ready         = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		queue_directed();
		queue_random_moves(230);
		drain();

		// widest period, shortest timeout: moves end on the first drive tick
		write_reg(CFG_PWM_TOP, 16'hFFFF);
		write_reg(CFG_TIMEOUT, 16'd1);
		queue_random_moves(200);
		drain();

		// period of one: every duty below full speed rounds to zero
		write_reg(CFG_PWM_TOP, 16'd1);
		write_reg(CFG_TIMEOUT, 16'hFFFF);
		queue_random_moves(200);
		drain();

		// zero period
		write_reg(CFG_PWM_TOP, 16'd0);
		write_reg(CFG_TIMEOUT, 16'd20);
		queue_random_moves(120);
		drain();

		write_reg(CFG_PWM_TOP, 16'($urandom_range(2, 65534)));
		write_reg(CFG_TIMEOUT, 16'($urandom_range(2, 40)));
		queue_random_moves(220);
		drain();

		write_reg(CFG_PWM_TOP, PWM_TOP_RST);
		write_reg(CFG_TIMEOUT, TIMEOUT_RST);
		queue_random_moves(200);
		drain();

		if (mismatch_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
